### sv/tcw_pkg.sv
// Shared types, constants and the control program of the text console writer.
package tcw_pkg;

    // Field widths of the request and result items
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int INDEX_W     = 11;
    localparam int CURSOR_W    = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Stream packing
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // Character codes and attribute reset values
    localparam logic [CHAR_W-1:0] NEWLINE_CODE      = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE        = 8'h20;
    localparam logic [ATTR_W-1:0] NORMAL_ATTR_RESET = 8'h07;
    localparam logic [ATTR_W-1:0] LOG_ATTR_RESET    = 8'hF0;

    // Request kinds
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_ATTR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_ATTR    = 1'b1;

    // Program steps
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_OUT,
        ST_PUT,
        ST_PUT_OUT,
        ST_SCR_START,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BLANK,
        ST_SCR_END
    } step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR_WR,
        DP_LATCH,
        DP_READ_REQ,
        DP_READ_OUT,
        DP_PUT,
        DP_PUT_OUT,
        DP_SCR_START,
        DP_COPY_RD,
        DP_COPY_WR,
        DP_BLANK_WR
    } dp_op_t;

    // Sequencer operations
    typedef enum logic [2:0] {
        SEQ_NEXT,      // go to the following step
        SEQ_JUMP,      // go to the target
        SEQ_DISPATCH,  // wait for a request, then read or put
        SEQ_LOOP,      // following step when the pointer hits its limit, else target
        SEQ_SCROLL     // target when the put runs off the last row, else following step
    } seq_op_t;

    // Pointer limit for loops
    typedef enum logic {
        LIM_ALL,   // last cell of the store
        LIM_BODY   // last cell that takes a copy during a scroll
    } lim_t;

    typedef struct packed {
        dp_op_t  dp_op;
        lim_t    lim;
        logic    loads_out;
        seq_op_t seq_op;
        step_t   target;
    } ctl_word_t;

    // Control store
    function automatic ctl_word_t ucode(input step_t step);
        ctl_word_t w;
        w = '{DP_NONE, LIM_ALL, 1'b0, SEQ_JUMP, ST_IDLE};
        case (step)
            ST_CLEAR:     w = '{DP_CLEAR_WR,  LIM_ALL,  1'b0, SEQ_LOOP,     ST_CLEAR};
            ST_IDLE:      w = '{DP_LATCH,     LIM_ALL,  1'b0, SEQ_DISPATCH, ST_READ};
            ST_READ:      w = '{DP_READ_REQ,  LIM_ALL,  1'b0, SEQ_NEXT,     ST_IDLE};
            ST_READ_OUT:  w = '{DP_READ_OUT,  LIM_ALL,  1'b1, SEQ_JUMP,     ST_IDLE};
            ST_PUT:       w = '{DP_PUT,       LIM_ALL,  1'b0, SEQ_SCROLL,   ST_SCR_START};
            ST_PUT_OUT:   w = '{DP_PUT_OUT,   LIM_ALL,  1'b1, SEQ_JUMP,     ST_IDLE};
            ST_SCR_START: w = '{DP_SCR_START, LIM_ALL,  1'b0, SEQ_NEXT,     ST_IDLE};
            ST_COPY_RD:   w = '{DP_COPY_RD,   LIM_BODY, 1'b0, SEQ_NEXT,     ST_IDLE};
            ST_COPY_WR:   w = '{DP_COPY_WR,   LIM_BODY, 1'b0, SEQ_LOOP,     ST_COPY_RD};
            ST_BLANK:     w = '{DP_BLANK_WR,  LIM_ALL,  1'b0, SEQ_LOOP,     ST_BLANK};
            ST_SCR_END:   w = '{DP_NONE,      LIM_ALL,  1'b0, SEQ_JUMP,     ST_PUT_OUT};
            default:      w = '{DP_NONE,      LIM_ALL,  1'b0, SEQ_JUMP,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/text_console_writer_top.sv
// Text console writer: screen store, cursor and a microcoded control sequencer.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tdata: char_code, cell_index; tuser: cmd, log_line
//  m_       out        m_tvalid/m_tready  tdata: cursor_position, cell_value; tuser: did_scroll
//  cfg_     in         cfg_we             cfg_index, cfg_data (attribute registers)
//
// A read or a put runs through accept, one store access and result load.
// A put that scrolls inserts the scroll steps before its result load: pointer
// reset, row copy, blanking of the last row and a closing step; the row copy
// reads and writes each cell in separate steps.
// After reset the store is cleared one cell a cycle, all ROWS*COLUMNS cells
// (2000 at 80x25); no request is taken until the pass ends.
// The result register holds while m_tready is low; the next request is
// still taken, and the sequencer only waits when a new result is due.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] char_code, [18:8] cell_index
    input  logic [tcw_pkg::S_TUSER_W-1:0]    s_tuser,  // [0] cmd, [1] log_line
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata,  // [10:0] cursor_position, [26:11] cell_value
    output logic [tcw_pkg::M_TUSER_W-1:0]    m_tuser,  // [0] did_scroll
    // Configuration
    input  logic                             cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS         = COLUMNS * ROWS;
    localparam int AW            = $clog2(CELLS);
    localparam int RW            = $clog2(ROWS);
    localparam int CW            = $clog2(COLUMNS);
    localparam int BODY_LAST     = CELLS - COLUMNS - 1;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // Sequencer
    step_t     pc_reg, pc_next;
    ctl_word_t ctl;
    logic      stall;
    logic      ptr_last;

    // Datapath registers
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic              scroll_reg, scroll_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              log_reg, log_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              oob_reg, oob_next;
    logic [ATTR_W-1:0] normal_attr_reg, normal_attr_next;
    logic [ATTR_W-1:0] log_attr_reg, log_attr_next;

    // Result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0]       out_pos_reg, out_pos_next;
    logic [CELL_W-1:0]   out_cell_reg, out_cell_next;
    logic                out_scroll_reg, out_scroll_next;
    logic                out_load;

    // Store port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Put decode
    logic is_newline;
    logic row_adv;
    logic put_scroll;

    assign ctl        = ucode(pc_reg);
    assign stall      = ctl.loads_out && m_tvalid_reg && !m_tready;
    assign ptr_last   = (ctl.lim == LIM_ALL) ? (ptr_reg == AW'(CELLS - 1))
                                             : (ptr_reg == AW'(BODY_LAST));
    assign is_newline = (char_reg == NEWLINE_CODE);
    assign row_adv    = is_newline || (col_reg == CW'(COLUMNS - 1));
    assign put_scroll = row_adv && (row_reg == RW'(ROWS - 1));

    // Next step
    always_comb begin
        pc_next = pc_reg;
        case (ctl.seq_op)
            SEQ_NEXT:     pc_next = step_t'(pc_reg + 4'd1);
            SEQ_JUMP:     pc_next = ctl.target;
            SEQ_DISPATCH: begin
                if (s_tvalid) begin
                    pc_next = (s_tuser[0] == CMD_READ) ? ctl.target : ST_PUT;
                end
            end
            SEQ_LOOP:     pc_next = ptr_last ? step_t'(pc_reg + 4'd1) : ctl.target;
            SEQ_SCROLL:   pc_next = put_scroll ? ctl.target : step_t'(pc_reg + 4'd1);
            default:      pc_next = ST_IDLE;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end
    end

    // Control outputs: store port, request ready, result load
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {NORMAL_ATTR_RESET, BLANK_CODE};
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        s_tready  = 1'b0;
        out_load  = 1'b0;
        case (ctl.dp_op)
            DP_CLEAR_WR: begin
                ram_we = 1'b1;
            end
            DP_LATCH: begin
                s_tready = 1'b1;
            end
            DP_READ_REQ: begin
                ram_re = 1'b1;
            end
            DP_PUT: begin
                ram_we    = !is_newline;
                ram_waddr = pos_reg;
                ram_wdata = {(log_reg ? log_attr_reg : normal_attr_reg), char_reg};
            end
            DP_COPY_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ptr_reg + AW'(COLUMNS);
            end
            DP_COPY_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            DP_BLANK_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {normal_attr_reg, BLANK_CODE};
            end
            DP_READ_OUT, DP_PUT_OUT: begin
                out_load = !stall;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        ptr_next         = ptr_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        pos_next         = pos_reg;
        scroll_next      = scroll_reg;
        char_next        = char_reg;
        log_next         = log_reg;
        idx_next         = idx_reg;
        oob_next         = oob_reg;
        out_pos_next     = out_pos_reg;
        out_cell_next    = out_cell_reg;
        out_scroll_next  = out_scroll_reg;
        normal_attr_next = normal_attr_reg;
        log_attr_next    = log_attr_reg;

        case (ctl.dp_op)
            // Advance the sweep pointer, wrapping after the last cell
            DP_CLEAR_WR, DP_COPY_WR, DP_BLANK_WR: begin
                if (ptr_last && ctl.lim == LIM_ALL) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            // Capture the request
            DP_LATCH: begin
                if (s_tvalid) begin
                    char_next = s_tdata[CHAR_W-1:0];
                    log_next  = s_tuser[1];
                    idx_next  = AW'(s_tdata[CHAR_W +: INDEX_W]);
                    oob_next  = (32'(s_tdata[CHAR_W +: INDEX_W]) >= 32'(CELLS));
                end
            end
            // Move the cursor after a put or newline
            DP_PUT: begin
                scroll_next = put_scroll;
                if (put_scroll) begin
                    col_next = '0;
                    pos_next = AW'(LAST_ROW_BASE);
                end else if (is_newline) begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                    pos_next = pos_reg + (AW'(COLUMNS) - AW'(col_reg));
                end else if (row_adv) begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                    pos_next = pos_reg + AW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                    pos_next = pos_reg + AW'(1);
                end
            end
            DP_SCR_START: begin
                ptr_next = '0;
            end
            DP_READ_OUT: begin
                if (out_load) begin
                    out_pos_next    = pos_reg;
                    out_cell_next   = oob_reg ? '0 : ram_rdata;
                    out_scroll_next = 1'b0;
                end
            end
            DP_PUT_OUT: begin
                if (out_load) begin
                    out_pos_next    = pos_reg;
                    out_cell_next   = '0;
                    out_scroll_next = scroll_reg;
                end
            end
            default: begin
            end
        endcase

        // Attribute register writes
        if (cfg_we) begin
            case (cfg_index)
                REG_NORMAL_ATTR: normal_attr_next = cfg_data;
                REG_LOG_ATTR:    log_attr_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Result valid: set on load, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= ST_CLEAR;
            ptr_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            pos_reg         <= '0;
            scroll_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            normal_attr_reg <= NORMAL_ATTR_RESET;
            log_attr_reg    <= LOG_ATTR_RESET;
        end else begin
            pc_reg          <= pc_next;
            ptr_reg         <= ptr_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            pos_reg         <= pos_next;
            scroll_reg      <= scroll_next;
            m_tvalid_reg    <= m_tvalid_next;
            normal_attr_reg <= normal_attr_next;
            log_attr_reg    <= log_attr_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        char_reg       <= char_next;
        log_reg        <= log_next;
        idx_reg        <= idx_next;
        oob_reg        <= oob_next;
        out_pos_reg    <= out_pos_next;
        out_cell_reg   <= out_cell_next;
        out_scroll_reg <= out_scroll_next;
    end

    // Screen store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - CELL_W - CURSOR_W)'(0), out_cell_reg,
                       CURSOR_W'(out_pos_reg)};
    assign m_tuser  = out_scroll_reg;

endmodule

### sv/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [tcw_pkg::M_TUSER_W-1:0]    m_tuser
);

    import tcw_pkg::*;

    localparam int CELLS         = COLUMNS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One request at a time: no request taken in the cycle after one
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

    // The cursor stays on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CELLS > 2048) || (32'(m_tdata[CURSOR_W-1:0]) < 32'(CELLS)))
        else $error("cursor position off screen");

    // A scrolling put leaves the cursor at the start of the last row and a zero cell
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[CURSOR_W-1:0] == CURSOR_W'(LAST_ROW_BASE) &&
            m_tdata[CURSOR_W +: CELL_W] == '0)
        else $error("scroll result with wrong cursor or cell");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);
